[rtl/gaab_pkg.sv]
// ----------------------------------------------------------------------------
// gaab_pkg: shared types, constants and tables of the glyph alpha atlas blender
// Holds the transfer structs, the operation and status codes, the slot layout
// and the colour scaling tables.
// ----------------------------------------------------------------------------
package gaab_pkg;

	// Slot layout: one slot per digit at every position but the dot position,
	// plus one shared slot for the dot.
	localparam int TEXT_POSITIONS = 6;
	localparam int CELL_PIXELS    = 2048;
	localparam int DIGITS         = 10;
	localparam int DOT_POSITION   = 2;
	localparam int SLOT_COUNT     = (TEXT_POSITIONS - 1) * DIGITS + 1;
	localparam int DOT_SLOT       = (TEXT_POSITIONS - 1) * DIGITS;
	localparam int SLOT_W         = $clog2(SLOT_COUNT);
	localparam int CNT_W          = $clog2(SLOT_COUNT + 1);
	localparam int MEM_DEPTH      = SLOT_COUNT * CELL_PIXELS;
	localparam int MEM_AW         = $clog2(MEM_DEPTH);
	localparam int CFG_IW         = 1;

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_NINE = 8'h39;
	localparam logic [7:0] ASCII_DOT  = 8'h2E;

	typedef enum logic [1:0] {
		OP_STORE      = 2'd0,
		OP_RESTORE    = 2'd1,
		OP_INVALIDATE = 2'd2,
		OP_NOP        = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_SLOT  = 2'd1,
		ST_NOT_VALID = 2'd2
	} status_t;

	typedef enum logic [CFG_IW-1:0] {
		REG_TEXT_COLOR = 1'b0,
		REG_BACK_COLOR = 1'b1
	} cfg_reg_t;

	// One input item.
	typedef struct packed {
		logic [1:0]  operation;
		logic [2:0]  text_position;
		logic [7:0]  symbol;
		logic [10:0] pixel_offset;
		logic [15:0] pixel;
		logic        cell_last;
	} req_t;

	// One result item.
	typedef struct packed {
		logic [15:0] out_pixel;
		logic        pixel_write;
		logic [7:0]  coverage;
		logic [1:0]  status;
		logic        atlas_ready;
	} rsp_t;

	// Slot lookup handed from the slot controller to the datapath.
	typedef struct packed {
		logic              slot_ok;
		logic [SLOT_W-1:0] slot;
		logic              cell_ok;
		logic              atlas_ready;
	} slot_look_t;

	// Channel values packed red, green, blue from index 2 down to 0.
	typedef logic [2:0][7:0] rgb8_t;

	typedef logic [7:0] up5_lut_t [32];
	typedef logic [7:0] up6_lut_t [64];
	typedef logic [4:0] down5_lut_t [256];
	typedef logic [5:0] down6_lut_t [256];

	// Rounded 5-bit to 8-bit expansion.
	function automatic up5_lut_t build_up5();
		up5_lut_t t;
		for (int i = 0; i < 32; i++) begin
			t[i] = 8'((i * 255 + 15) / 31);
		end
		return t;
	endfunction

	// Rounded 6-bit to 8-bit expansion.
	function automatic up6_lut_t build_up6();
		up6_lut_t t;
		for (int i = 0; i < 64; i++) begin
			t[i] = 8'((i * 255 + 31) / 63);
		end
		return t;
	endfunction

	// Rounded 8-bit to 5-bit reduction.
	function automatic down5_lut_t build_down5();
		down5_lut_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = 5'((i * 31 + 127) / 255);
		end
		return t;
	endfunction

	// Rounded 8-bit to 6-bit reduction.
	function automatic down6_lut_t build_down6();
		down6_lut_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = 6'((i * 63 + 127) / 255);
		end
		return t;
	endfunction

	localparam up5_lut_t   UP5_LUT   = build_up5();
	localparam up6_lut_t   UP6_LUT   = build_up6();
	localparam down5_lut_t DOWN5_LUT = build_down5();
	localparam down6_lut_t DOWN6_LUT = build_down6();

	// Expands an RGB565 word to three 8-bit channels.
	function automatic rgb8_t expand565(input logic [15:0] c);
		rgb8_t r;
		r[2] = UP5_LUT[c[15:11]];
		r[1] = UP6_LUT[c[10:5]];
		r[0] = UP5_LUT[c[4:0]];
		return r;
	endfunction

endpackage

[rtl/gaab_slot_ctrl.sv]
// ----------------------------------------------------------------------------
// gaab_slot_ctrl: slot decode and cell valid tracking
// Maps a text position and symbol to a slot, keeps one valid flag per slot
// and the count of valid slots, and reports whether the atlas is complete.
// ----------------------------------------------------------------------------
module gaab_slot_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  gaab_pkg::req_t         req,
	output gaab_pkg::slot_look_t   look
);
	import gaab_pkg::*;

	logic [SLOT_COUNT-1:0] cell_valid_q;
	logic [CNT_W-1:0]      valid_cells_q;
	logic [CNT_W-1:0]      valid_cells_nxt;
	logic [2:0]            dense;
	logic [3:0]            digit;
	logic                  is_digit;
	logic                  set_cell;
	logic                  clear_all;

	// Position and symbol to slot number, then the count of valid slots as it
	// stands after this transfer.
	always_comb begin
		digit    = 4'(req.symbol - ASCII_ZERO);
		is_digit = (req.symbol >= ASCII_ZERO) && (req.symbol <= ASCII_NINE);
		dense    = (req.text_position < 3'(DOT_POSITION)) ? req.text_position
		         : req.text_position - 3'd1;
		look.slot_ok = 1'b0;
		look.slot    = '0;
		if ({1'b0, req.text_position} < 4'(TEXT_POSITIONS)) begin
			if (req.text_position == 3'(DOT_POSITION)) begin
				look.slot_ok = (req.symbol == ASCII_DOT);
				look.slot    = SLOT_W'(DOT_SLOT);
			end else begin
				look.slot_ok = is_digit;
				look.slot    = SLOT_W'(dense) * SLOT_W'(DIGITS) + SLOT_W'(digit);
			end
		end
		look.cell_ok = look.slot_ok && cell_valid_q[look.slot];

		set_cell  = accept && (req.operation == OP_STORE) && look.slot_ok
		         && req.cell_last && !look.cell_ok;
		clear_all = accept && (req.operation == OP_INVALIDATE);
		if (clear_all) begin
			valid_cells_nxt = '0;
		end else if (set_cell) begin
			valid_cells_nxt = valid_cells_q + CNT_W'(1);
		end else begin
			valid_cells_nxt = valid_cells_q;
		end
		look.atlas_ready = (valid_cells_nxt == CNT_W'(SLOT_COUNT));
	end

	// Valid flags and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_valid_q  <= '0;
			valid_cells_q <= '0;
		end else begin
			if (clear_all) begin
				cell_valid_q <= '0;
			end else if (set_cell) begin
				cell_valid_q[look.slot] <= 1'b1;
			end
			valid_cells_q <= valid_cells_nxt;
		end
	end

endmodule

[rtl/gaab_cov_ram.sv]
// ----------------------------------------------------------------------------
// gaab_cov_ram: coverage store
// Single-port synchronous memory of 8-bit coverage values, one row of
// CELL_PIXELS bytes per slot, with a registered read.
// ----------------------------------------------------------------------------
module gaab_cov_ram (
	input  logic                        clk,
	input  logic                        we,
	input  logic                        re,
	input  logic [gaab_pkg::MEM_AW-1:0] addr,
	input  logic [7:0]                  wdata,
	output logic [7:0]                  rdata
);
	import gaab_pkg::*;

	logic [7:0] mem [MEM_DEPTH];

	// Write and registered read at the same address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

[rtl/gaab_blend.sv]
// ----------------------------------------------------------------------------
// gaab_blend: foreground over background blend
// Registers the weighted channel sums, then divides by 255 with shifts and
// reduces each channel back to RGB565.
// ----------------------------------------------------------------------------
module gaab_blend (
	input  logic            clk,
	input  logic            en,
	input  logic [7:0]      cov,
	input  gaab_pkg::rgb8_t fg8,
	input  gaab_pkg::rgb8_t bg8,
	input  logic [15:0]     text_color,
	output logic [15:0]     blend_px
);
	import gaab_pkg::*;

	logic [2:0][15:0] sum_s2;
	logic             full_s2;
	logic [2:0][16:0] quo;
	logic [2:0][7:0]  mix8;
	logic [7:0]       inv;

	// Weighted sums per channel, with the rounding term.
	assign inv = 8'd255 - cov;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sum_s2[i] <= 16'(fg8[i]) * 16'(cov) + 16'(bg8[i]) * 16'(inv) + 16'd127;
			end
			full_s2 <= (cov == 8'd255);
		end
	end

	// Exact division by 255 for sums below 65535, then back to RGB565.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			quo[i]  = 17'(sum_s2[i]) + 17'(sum_s2[i] >> 8) + 17'd1;
			mix8[i] = quo[i][15:8];
		end
		if (full_s2) begin
			blend_px = text_color;
		end else begin
			blend_px = {DOWN5_LUT[mix8[2]], DOWN6_LUT[mix8[1]], DOWN5_LUT[mix8[0]]};
		end
	end

endmodule

[rtl/glyph_alpha_atlas_blender.sv]
// ----------------------------------------------------------------------------
// glyph_alpha_atlas_blender: RGB565 alpha-mask glyph cache for DD.DDD text
// Stores per-pixel coverage for each slot and blends the text colour over the
// background colour when a glyph is restored.
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  gaab_pkg::req_t
//  rsp      out        rsp_valid / rsp_stall  gaab_pkg::rsp_t
//  cfg      in         cfg_we                 cfg_index, cfg_data
//
// One item is taken per cycle while req_stall is low; each result moves through
// the s1 and s2 registers into the output register. Slot lookup, valid flags
// and the coverage memory access all happen at the transfer edge, so
// consecutive items to the same entry see each other's writes. A stalled
// output freezes the whole pipeline and raises req_stall. Reset clears the
// valid flags and count at once; the coverage memory is not cleared.
// ----------------------------------------------------------------------------
module glyph_alpha_atlas_blender (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  gaab_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output gaab_pkg::rsp_t              rsp,
	input  logic                        cfg_we,
	input  logic [gaab_pkg::CFG_IW-1:0] cfg_index,
	input  logic [15:0]                 cfg_data
);
	import gaab_pkg::*;

	logic        advance;
	logic        accept;
	logic        is_store;
	logic        is_restore;
	logic        off_ok;
	slot_look_t  look;

	logic [15:0] text_color_q;
	logic [15:0] back_color_q;
	rgb8_t       fg8_q;
	rgb8_t       bg8_q;

	rgb8_t       px8;
	logic [2:0]  rise;
	rgb8_t       diff;
	logic [7:0]  max_rg;
	logic [7:0]  max_rgb;
	logic [7:0]  store_cov;

	logic              ram_we;
	logic [MEM_AW-1:0] ram_addr;
	logic [7:0]        ram_rdata;

	logic        valid_s1;
	logic        restore_s1;
	logic        off_ok_s1;
	logic [15:0] pixel_s1;
	logic [7:0]  cov_s1;
	status_t     status_s1;
	logic        ready_s1;
	logic [7:0]  cov_res_s1;

	logic        valid_s2;
	logic        draw_s2;
	logic [15:0] pixel_s2;
	logic [7:0]  cov_s2;
	status_t     status_s2;
	logic        ready_s2;
	logic [15:0] blend_px;

	logic        rsp_valid_q;
	rsp_t        rsp_q;

	// Pipeline moves whenever the output register is free or being emptied.
	assign advance    = !rsp_valid_q || !rsp_stall;
	assign req_stall  = !advance;
	assign accept     = req_valid && advance;
	assign is_store   = (req.operation == OP_STORE);
	assign is_restore = (req.operation == OP_RESTORE);
	assign off_ok     = 32'(req.pixel_offset) < 32'(CELL_PIXELS);

	// Configuration registers, with the colours also kept expanded to 8 bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= 16'hFFFF;
			back_color_q <= 16'h0000;
			fg8_q        <= '1;
			bg8_q        <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TEXT_COLOR: begin
					text_color_q <= cfg_data;
					fg8_q        <= expand565(cfg_data);
				end
				REG_BACK_COLOR: begin
					back_color_q <= cfg_data;
					bg8_q        <= expand565(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	gaab_slot_ctrl u_slot_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (req),
		.look   (look)
	);

	// Coverage of a captured pixel: largest channel rise over the background.
	always_comb begin
		px8 = expand565(req.pixel);
		for (int i = 0; i < 3; i++) begin
			rise[i] = px8[i] > bg8_q[i];
			diff[i] = rise[i] ? px8[i] - bg8_q[i] : 8'd0;
		end
		max_rg  = (diff[2] > diff[1]) ? diff[2] : diff[1];
		max_rgb = (diff[0] > max_rg) ? diff[0] : max_rg;
		if (req.pixel == back_color_q) begin
			store_cov = 8'd0;
		end else if (|rise) begin
			store_cov = max_rgb;
		end else begin
			store_cov = 8'd255;
		end
	end

	// Coverage memory access at the transfer edge.
	assign ram_addr = MEM_AW'(look.slot) * MEM_AW'(CELL_PIXELS)
	                + MEM_AW'(req.pixel_offset);
	assign ram_we   = accept && is_store && look.slot_ok && off_ok;

	gaab_cov_ram u_cov_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (advance),
		.addr  (ram_addr),
		.wdata (store_cov),
		.rdata (ram_rdata)
	);

	// Pipeline valid bits and the output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= accept;
			valid_s2    <= valid_s1;
			rsp_valid_q <= valid_s2;
		end
	end

	// First stage: decoded item alongside the memory read.
	always_ff @(posedge clk) begin
		if (advance) begin
			restore_s1 <= is_restore && look.slot_ok && look.cell_ok;
			off_ok_s1  <= off_ok;
			pixel_s1   <= req.pixel;
			cov_s1     <= (is_store && look.slot_ok) ? store_cov : 8'd0;
			ready_s1   <= look.atlas_ready;
			if ((is_store || is_restore) && !look.slot_ok) begin
				status_s1 <= ST_BAD_SLOT;
			end else if (is_restore && !look.cell_ok) begin
				status_s1 <= ST_NOT_VALID;
			end else begin
				status_s1 <= ST_OK;
			end
		end
	end

	// Coverage reported for the item: read back on restore, computed on store.
	always_comb begin
		if (restore_s1) begin
			cov_res_s1 = off_ok_s1 ? ram_rdata : 8'd0;
		end else begin
			cov_res_s1 = cov_s1;
		end
	end

	gaab_blend u_blend (
		.clk        (clk),
		.en         (advance),
		.cov        (cov_res_s1),
		.fg8        (fg8_q),
		.bg8        (bg8_q),
		.text_color (text_color_q),
		.blend_px   (blend_px)
	);

	// Second stage: fields that travel beside the blend sums.
	always_ff @(posedge clk) begin
		if (advance) begin
			draw_s2   <= restore_s1 && (cov_res_s1 != 8'd0);
			pixel_s2  <= pixel_s1;
			cov_s2    <= cov_res_s1;
			status_s2 <= status_s1;
			ready_s2  <= ready_s1;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.out_pixel   <= draw_s2 ? blend_px : pixel_s2;
			rsp_q.pixel_write <= draw_s2;
			rsp_q.coverage    <= cov_s2;
			rsp_q.status      <= status_s2;
			rsp_q.atlas_ready <= ready_s2;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the glyph alpha atlas blender
// Stores glyph cells, restores and blends them, invalidates the atlas and
// sends malformed items. Each random phase sets its own pair of colours. A
// predictor that keeps its own atlas state computes each expected result
// when the item is transferred. The monitor compares every result with the
// oldest expected one, field by field. Both sides idle at random in some
// phases and not at all in others.
// ----------------------------------------------------------------------------
module tb;
	import gaab_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	req_t                req = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	rsp_t                rsp;
	logic                cfg_we = 1'b0;
	logic [CFG_IW-1:0]   cfg_index = '0;
	logic [15:0]         cfg_data = '0;

	// Items waiting to be sent and results that are still owed.
	req_t                pixel_jobs [$];
	rsp_t                atlas_replies [$];
	int                  jobs_queued = 0;
	int                  jobs_taken = 0;
	int                  real_items = 0;
	int                  mismatches = 0;
	int                  snd_idle_pct = 0;
	int                  rcv_idle_pct = 0;
	logic                req_took = 1'b0;

	// Predicted state of the atlas and its colour registers.
	logic [7:0]          cov_mem [MEM_DEPTH];
	bit                  cell_ok [SLOT_COUNT];
	int                  cells_ok_cnt = 0;
	logic [15:0]         text_colour = 16'hFFFF;
	logic [15:0]         back_colour = 16'h0000;

	// What the stimulus has stored so far, so that no unwritten entry is read.
	bit                  gen_written [MEM_DEPTH];
	bit                  gen_valid [SLOT_COUNT];
	int                  last_off [SLOT_COUNT];

	glyph_alpha_atlas_blender DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Colour scaling with rounding, 5 and 6 bits to 8 and back.
	function automatic int up5(logic [4:0] v);
		return (int'(v) * 255 + 15) / 31;
	endfunction

	function automatic int up6(logic [5:0] v);
		return (int'(v) * 255 + 31) / 63;
	endfunction

	function automatic int down5(int v);
		return (v * 31 + 127) / 255;
	endfunction

	function automatic int down6(int v);
		return (v * 63 + 127) / 255;
	endfunction

	function automatic int mix8(int f, int b, int a);
		return (f * a + b * (255 - a) + 127) / 255;
	endfunction

	// Slot of a position and symbol, or -1 when the pair is not allowed.
	function automatic int slot_of(logic [2:0] pos, logic [7:0] sym);
		if (pos >= TEXT_POSITIONS) return -1;
		if (pos == DOT_POSITION) return (sym == ASCII_DOT) ? DOT_SLOT : -1;
		if (sym < ASCII_ZERO || sym > ASCII_NINE) return -1;
		return ((pos < DOT_POSITION) ? int'(pos) : int'(pos) - 1) * DIGITS
			+ int'(sym - ASCII_ZERO);
	endfunction

	// Coverage is the largest rise of any channel over the background.
	function automatic logic [7:0] coverage_from(logic [15:0] px, logic [15:0] bg);
		int dr, dg, db, m;
		if (px == bg) return 8'h00;
		dr = up5(px[15:11]) - up5(bg[15:11]);
		dg = up6(px[10:5]) - up6(bg[10:5]);
		db = up5(px[4:0]) - up5(bg[4:0]);
		m = (dr > dg) ? dr : dg;
		if (db > m) m = db;
		if (m <= 0) return 8'hFF;
		return (m > 255) ? 8'hFF : 8'(m);
	endfunction

	function automatic logic [15:0] blend_565(logic [15:0] fg, logic [15:0] bg,
			logic [7:0] a);
		int r, g, b;
		if (a == 8'hFF) return fg;
		r = mix8(up5(fg[15:11]), up5(bg[15:11]), int'(a));
		g = mix8(up6(fg[10:5]), up6(bg[10:5]), int'(a));
		b = mix8(up5(fg[4:0]), up5(bg[4:0]), int'(a));
		return {5'(down5(r)), 6'(down6(g)), 5'(down5(b))};
	endfunction

	// Applies one item to the predicted atlas and returns the result it owes.
	function automatic rsp_t atlas_step(req_t r);
		rsp_t o;
		int s;
		logic [7:0] c;
		o = '0;
		o.out_pixel = r.pixel;
		case (op_t'(r.operation))
			OP_STORE, OP_RESTORE: begin
				s = slot_of(r.text_position, r.symbol);
				if (s < 0) begin
					o.status = ST_BAD_SLOT;
				end else if (r.operation == OP_STORE) begin
					c = coverage_from(r.pixel, back_colour);
					o.coverage = c;
					if (r.pixel_offset < CELL_PIXELS)
						cov_mem[s * CELL_PIXELS + int'(r.pixel_offset)] = c;
					if (r.cell_last && !cell_ok[s]) begin
						cell_ok[s] = 1'b1;
						cells_ok_cnt++;
					end
				end else if (!cell_ok[s]) begin
					o.status = ST_NOT_VALID;
				end else begin
					c = 8'h00;
					if (r.pixel_offset < CELL_PIXELS)
						c = cov_mem[s * CELL_PIXELS + int'(r.pixel_offset)];
					o.coverage = c;
					if (c != 8'h00) begin
						o.out_pixel = blend_565(text_colour, back_colour, c);
						o.pixel_write = 1'b1;
					end
				end
			end
			OP_INVALIDATE: begin
				foreach (cell_ok[i]) cell_ok[i] = 1'b0;
				cells_ok_cnt = 0;
			end
			default: ;
		endcase
		o.atlas_ready = (cells_ok_cnt == SLOT_COUNT);
		return o;
	endfunction

	function automatic req_t glyph_req(op_t op, logic [2:0] pos, logic [7:0] sym,
			int off, logic [15:0] px, bit last);
		req_t r;
		r.operation = op;
		r.text_position = pos;
		r.symbol = sym;
		r.pixel_offset = 11'(off);
		r.pixel = px;
		r.cell_last = last;
		return r;
	endfunction

	// Pixels equal to, below or unrelated to the background colour.
	function automatic logic [15:0] rand_pixel();
		case ($urandom_range(3))
			0: return back_colour;
			1: return back_colour & 16'($urandom);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic glyph_of_slot(int s, output logic [2:0] pos, output logic [7:0] sym);
		if (s == DOT_SLOT) begin
			pos = 3'(DOT_POSITION);
			sym = ASCII_DOT;
		end else begin
			pos = 3'((s / DIGITS < DOT_POSITION) ? s / DIGITS : s / DIGITS + 1);
			sym = ASCII_ZERO + 8'(s % DIGITS);
		end
	endtask

	// Queues one item. A restore that would read a never written entry of a
	// valid cell is moved to the last offset stored in that cell.
	task automatic queue_item(input req_t r);
		int s, idx;
		s = slot_of(r.text_position, r.symbol);
		if (s >= 0) begin
			idx = s * CELL_PIXELS + int'(r.pixel_offset);
			if (r.operation == OP_STORE) begin
				gen_written[idx] = 1'b1;
				last_off[s] = int'(r.pixel_offset);
				if (r.cell_last) gen_valid[s] = 1'b1;
			end else if (r.operation == OP_RESTORE && gen_valid[s] && !gen_written[idx]) begin
				r.pixel_offset = 11'(last_off[s]);
			end
		end
		if (r.operation == OP_INVALIDATE) begin
			foreach (gen_valid[i]) gen_valid[i] = 1'b0;
		end
		if (r.operation != OP_NOP) real_items++;
		jobs_queued++;
		pixel_jobs.push_back(r);
	endtask

	// Random part: mostly a cell stored and then read back, with restore
	// bursts, whole atlas fills, invalidates and malformed items mixed in.
	task automatic random_items(int target);
		int start, kind, n, m, base;
		logic [2:0] pos;
		logic [7:0] sym;
		req_t r;
		start = real_items;
		while (real_items - start < target) begin
			kind = $urandom_range(99);
			glyph_of_slot($urandom_range(SLOT_COUNT - 1), pos, sym);
			if (kind < 55) begin
				n = $urandom_range(12, 1);
				base = $urandom_range(CELL_PIXELS - n);
				for (int i = 0; i < n; i++)
					queue_item(glyph_req(OP_STORE, pos, sym, base + i, rand_pixel(),
						i == n - 1 && $urandom_range(9) != 0));
				m = $urandom_range(12, 1);
				for (int i = 0; i < m; i++)
					queue_item(glyph_req(OP_RESTORE, pos, sym, base + $urandom_range(n - 1),
						16'($urandom), 1'($urandom)));
			end else if (kind < 70) begin
				m = $urandom_range(8, 1);
				for (int i = 0; i < m; i++)
					queue_item(glyph_req(OP_RESTORE, pos, sym, $urandom_range(CELL_PIXELS - 1),
						16'($urandom), 1'($urandom)));
			end else if (kind < 73) begin
				for (int s = 0; s < SLOT_COUNT; s++) begin
					glyph_of_slot(s, pos, sym);
					queue_item(glyph_req(OP_STORE, pos, sym, $urandom_range(CELL_PIXELS - 1),
						rand_pixel(), 1'b1));
				end
				for (int i = 0; i < 10; i++) begin
					glyph_of_slot($urandom_range(SLOT_COUNT - 1), pos, sym);
					queue_item(glyph_req(OP_RESTORE, pos, sym, $urandom_range(CELL_PIXELS - 1),
						16'($urandom), 1'($urandom)));
				end
			end else if (kind < 76) begin
				queue_item(glyph_req(OP_INVALIDATE, 3'($urandom), 8'($urandom),
					$urandom_range(CELL_PIXELS - 1), 16'($urandom), 1'($urandom)));
			end else begin
				r = glyph_req(op_t'(2'($urandom)), 3'($urandom), 8'($urandom),
					$urandom_range(CELL_PIXELS - 1), 16'($urandom), 1'($urandom));
				if ($urandom_range(1)) begin
					r.text_position = pos;
					r.symbol = sym;
				end
				queue_item(r);
			end
		end
	endtask

	task automatic write_colour(cfg_reg_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_TEXT_COLOR) text_colour = val;
		else back_colour = val;
	endtask

	// Holds off until every queued item has been taken and answered.
	task automatic wait_drain();
		do @(negedge clk);
		while (jobs_taken != jobs_queued || atlas_replies.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic check_field(string what, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
			mismatches++;
		end
	endtask

	// Driver: offers the next item once the previous one has been transferred.
	always @(negedge clk) begin : drive
		req_t nxt;
		if (arst_n) begin
			if (!req_valid || req_took) begin
				if (pixel_jobs.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
					nxt = pixel_jobs.pop_front();
					req <= nxt;
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
			rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	// Monitor: predicts each transferred item and checks each result.
	always @(posedge clk) begin : watch
		rsp_t want;
		if (arst_n) begin
			req_took <= req_valid && !req_stall;
			if (req_valid && !req_stall) begin
				atlas_replies.push_back(atlas_step(req));
				jobs_taken++;
			end
			if (rsp_valid && !rsp_stall) begin
				if (atlas_replies.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, actual %h", $time, rsp);
					mismatches++;
				end else begin
					want = atlas_replies.pop_front();
					check_field("out_pixel", want.out_pixel, rsp.out_pixel);
					check_field("pixel_write", 16'(want.pixel_write), 16'(rsp.pixel_write));
					check_field("coverage", 16'(want.coverage), 16'(rsp.coverage));
					check_field("status", 16'(want.status), 16'(rsp.status));
					check_field("atlas_ready", 16'(want.atlas_ready), 16'(rsp.atlas_ready));
				end
			end
		end
	end

	// Stimulus: reset, directed items at reset colours, then random phases.
	initial begin : stim
		logic [15:0] fg, bg;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		snd_idle_pct = 14;
		rcv_idle_pct = 47;

		// Directed part: error cases, extremes of coverage and invalidate.
		queue_item(glyph_req(OP_RESTORE, 3'd0, ASCII_ZERO, 0, 16'h1111, 1'b0));
		queue_item(glyph_req(OP_STORE, 3'd0, ASCII_ZERO, 0, 16'hFFFF, 1'b0));
		queue_item(glyph_req(OP_STORE, 3'd0, ASCII_ZERO, CELL_PIXELS - 1, 16'h0000, 1'b1));
		queue_item(glyph_req(OP_RESTORE, 3'd0, ASCII_ZERO, 0, 16'h1234, 1'b0));
		queue_item(glyph_req(OP_RESTORE, 3'd0, ASCII_ZERO, CELL_PIXELS - 1, 16'hABCD, 1'b0));
		queue_item(glyph_req(OP_STORE, 3'd2, ASCII_DOT, 5, 16'h0841, 1'b1));
		queue_item(glyph_req(OP_RESTORE, 3'd2, ASCII_DOT, 5, 16'h5555, 1'b1));
		queue_item(glyph_req(OP_STORE, 3'd2, ASCII_ZERO + 8'd5, 9, 16'hFFFF, 1'b1));
		queue_item(glyph_req(OP_RESTORE, 3'd3, ASCII_DOT, 0, 16'h2222, 1'b0));
		queue_item(glyph_req(OP_STORE, 3'd6, ASCII_ZERO + 8'd1, 7, 16'h7777, 1'b1));
		queue_item(glyph_req(OP_RESTORE, 3'd7, ASCII_NINE, 7, 16'h3333, 1'b0));
		queue_item(glyph_req(OP_STORE, 3'd1, ASCII_ZERO - 8'd1, 2, 16'hF000, 1'b0));
		queue_item(glyph_req(OP_STORE, 3'd4, ASCII_NINE + 8'd1, 2, 16'h0F00, 1'b0));
		queue_item(glyph_req(OP_STORE, 3'd5, ASCII_NINE, 1, 16'h8410, 1'b1));
		queue_item(glyph_req(OP_RESTORE, 3'd5, ASCII_NINE, 1, 16'h0000, 1'b1));
		queue_item(glyph_req(OP_STORE, 3'd1, ASCII_ZERO, 3, 16'h07E0, 1'b1));
		queue_item(glyph_req(OP_STORE, 3'd4, 8'hFF, CELL_PIXELS - 1, 16'hFFFF, 1'b1));
		queue_item(glyph_req(OP_NOP, 3'd7, 8'hFF, CELL_PIXELS - 1, 16'hFFFF, 1'b1));
		queue_item(glyph_req(OP_INVALIDATE, 3'd5, 8'hA5, 1234, 16'h5A5A, 1'b1));
		queue_item(glyph_req(OP_RESTORE, 3'd5, ASCII_NINE, 1, 16'h4444, 1'b0));
		queue_item(glyph_req(OP_STORE, 3'd5, ASCII_NINE, 1, 16'hFFFF, 1'b1));
		queue_item(glyph_req(OP_RESTORE, 3'd5, ASCII_NINE, 1, 16'h6666, 1'b0));
		wait_drain();

		// Random phases; the colours change only while the block is empty.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					fg = 16'h0000;
					bg = 16'hFFFF;
				end
				1: begin
					fg = 16'hFFFF;
					bg = 16'h0000;
				end
				3: begin
					fg = 16'hF800;
					bg = 16'h07E0;
				end
				default: begin
					fg = 16'($urandom);
					bg = 16'($urandom);
				end
			endcase
			snd_idle_pct = (ph < 2) ? 14 : (ph < 4) ? 47 : 0;
			rcv_idle_pct = (ph < 2) ? 47 : (ph < 4) ? 14 : 0;
			write_colour(REG_TEXT_COLOR, fg);
			write_colour(REG_BACK_COLOR, bg);
			random_items(160);
			wait_drain();
			random_items(165);
			wait_drain();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
